// ----- hw/rtl/psf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pendulum state feedback package
// Payload types, register indexes, fixed-point constants and the microcode
// program of the state feedback sequencer.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int SAMPLE_BITS        = 10;
   localparam int PULSE_BITS         = 12;
   localparam int GAIN_FRACTION_BITS = 24;

   // Q30 alignment shifts for position (Q10.22) and angle (Q4.28) terms
   localparam int RND_POS_SHIFT = GAIN_FRACTION_BITS - 8;
   localparam int RND_ANG_SHIFT = GAIN_FRACTION_BITS - 2;
   localparam int PULSE_SHIFT   = 10;
   localparam int DRIVE_SHIFT   = 15;

   localparam logic signed [32:0] ANGLE_PER_COUNT = 33'sd718187;
   localparam logic signed [32:0] HALF_MPP_Q32    = 33'sd1088774;
   localparam logic signed [33:0] POS_LIMIT       = 34'sd2097152000;
   localparam logic signed [63:0] DRIVE_MAX       = 64'sd32767;
   localparam logic signed [63:0] ANGLE_MAX       = 64'sd2147483647;
   localparam logic signed [63:0] ANGLE_MIN       = -64'sd2147483648;

   localparam logic signed [31:0] GAIN_POSITION_RST   = -32'sd101016;
   localparam logic signed [31:0] GAIN_VELOCITY_RST   = -32'sd1577427;
   localparam logic signed [31:0] GAIN_ANGLE_RST      = -32'sd343765240;
   localparam logic signed [31:0] GAIN_ANGLE_RATE_RST = 32'sd150995;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_POSITION   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_VELOCITY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ANGLE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ANGLE_RATE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_OFFSET    = 3'd4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]        angle_sample;
      logic signed [PULSE_BITS-1:0]  left_pulses;
      logic signed [PULSE_BITS-1:0]  right_pulses;
      logic                          zero_position;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               drive_clipped;
   } rsp_type;

   // multiplier operand pairs
   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_SAMPLE = 3'd1;
   localparam logic [2:0] MUL_PULSES = 3'd2;
   localparam logic [2:0] MUL_ANGLE  = 3'd3;
   localparam logic [2:0] MUL_POS    = 3'd4;
   localparam logic [2:0] MUL_VEL    = 3'd5;
   localparam logic [2:0] MUL_RATE   = 3'd6;

   // accumulator operations
   localparam logic [1:0] ACC_HOLD     = 2'd0;
   localparam logic [1:0] ACC_LOAD     = 2'd1;
   localparam logic [1:0] ACC_ADD      = 2'd2;
   localparam logic [1:0] ACC_ADD_X100 = 2'd3;

   // rounding shift selects
   localparam logic RND_POS = 1'b0;
   localparam logic RND_ANG = 1'b1;

   // jump conditions
   localparam logic [1:0] COND_NEVER    = 2'd0;
   localparam logic [1:0] COND_NO_REQ   = 2'd1;
   localparam logic [1:0] COND_RSP_BUSY = 2'd2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

   typedef struct packed {
      logic              take_req;
      logic [2:0]        mul_sel;
      logic              th_load;
      logic              pos_load;
      logic [1:0]        acc_op;
      logic              rnd_sel;
      logic              finish;
      logic [1:0]        cond;
      logic [STEP_W-1:0] jump_target;
      logic              seq_end;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         4'd0: begin
            w.take_req    = 1'b1;
            w.cond        = COND_NO_REQ;
            w.jump_target = STEP_IDLE;
         end
         4'd1: w.mul_sel = MUL_SAMPLE;
         4'd2: begin
            w.th_load = 1'b1;
            w.mul_sel = MUL_PULSES;
         end
         4'd3: begin
            w.pos_load = 1'b1;
            w.mul_sel  = MUL_ANGLE;
         end
         4'd4: begin
            w.acc_op  = ACC_LOAD;
            w.rnd_sel = RND_ANG;
            w.mul_sel = MUL_POS;
         end
         4'd5: begin
            w.acc_op  = ACC_ADD;
            w.rnd_sel = RND_POS;
            w.mul_sel = MUL_VEL;
         end
         4'd6: begin
            w.acc_op  = ACC_ADD_X100;
            w.rnd_sel = RND_POS;
            w.mul_sel = MUL_RATE;
         end
         4'd7: begin
            w.acc_op  = ACC_ADD_X100;
            w.rnd_sel = RND_ANG;
         end
         4'd8: begin
            w.finish      = 1'b1;
            w.cond        = COND_RSP_BUSY;
            w.jump_target = STEP_LAST;
            w.seq_end     = 1'b1;
         end
         default: begin
            w.seq_end = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pendulum_state_feedback_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A tick transferred at step 0 runs through steps 1 to 8; its drive result is registered at step 8.
// Ticks do not overlap: the microcode program runs on one shared 33x33 multiplier and takes a new tick only at step 0.
// A new tick is taken while the previous result still waits; a stalled result holds step 8.
// Reset (synchronous): gains to their defaults, angle offset, position and history to zero.
// No clearing pass; the block takes a tick in the first cycle after reset.
// ----------------------------------------------------------------------------
// Pendulum state feedback unit
// Four-state feedback drive computed by a microcoded sequencer around one
// multiplier, one rounding stage and a 64-bit accumulator.
// ----------------------------------------------------------------------------
module pendulum_state_feedback_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  psf_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output psf_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_we,
   input  wire [psf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire [31:0]                            csr_wdata
);

   logic signed [31:0] gain_position_ff;
   logic signed [31:0] gain_velocity_ff;
   logic signed [31:0] gain_angle_ff;
   logic signed [31:0] gain_angle_rate_ff;
   logic        [29:0] angle_offset_ff;

   logic [psf_pkg::STEP_W-1:0] step_ff, step_in;
   psf_pkg::ctrl_word_type     ctl;
   logic                       cond_hit;
   logic                       go;

   psf_pkg::req_type   req_ff;
   logic signed [31:0] th_ff, th_in;
   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] last_position_ff;
   logic signed [31:0] last_angle_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic               rsp_valid_ff;
   psf_pkg::rsp_type   rsp_ff, rsp_in;

   logic signed [psf_pkg::PULSE_BITS:0] pulse_diff;
   logic signed [32:0] dx;
   logic signed [32:0] dth;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] product;
   logic signed [63:0] rnd;
   logic signed [63:0] rnd_x100;
   logic signed [63:0] th_wide;
   logic signed [63:0] pos_round;
   logic signed [31:0] pos_base;
   logic signed [33:0] pos_sum;
   logic signed [63:0] drive_wide;
   logic               req_take;
   logic               rsp_take;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_position_ff   <= psf_pkg::GAIN_POSITION_RST;
         gain_velocity_ff   <= psf_pkg::GAIN_VELOCITY_RST;
         gain_angle_ff      <= psf_pkg::GAIN_ANGLE_RST;
         gain_angle_rate_ff <= psf_pkg::GAIN_ANGLE_RATE_RST;
         angle_offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            psf_pkg::CSR_GAIN_POSITION:   gain_position_ff   <= $signed(csr_wdata);
            psf_pkg::CSR_GAIN_VELOCITY:   gain_velocity_ff   <= $signed(csr_wdata);
            psf_pkg::CSR_GAIN_ANGLE:      gain_angle_ff      <= $signed(csr_wdata);
            psf_pkg::CSR_GAIN_ANGLE_RATE: gain_angle_rate_ff <= $signed(csr_wdata);
            psf_pkg::CSR_ANGLE_OFFSET:    angle_offset_ff    <= csr_wdata[29:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      ctl = psf_pkg::ucode(step_ff);
      case (ctl.cond)
         psf_pkg::COND_NO_REQ:   cond_hit = !req_valid;
         psf_pkg::COND_RSP_BUSY: cond_hit = rsp_valid_ff && rsp_stall;
         default:                cond_hit = 1'b0;
      endcase
      go = !cond_hit;
      if (cond_hit) begin
         step_in = ctl.jump_target;
      end else if (ctl.seq_end) begin
         step_in = psf_pkg::STEP_IDLE;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   assign req_stall = !ctl.take_req;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // datapath
   always_comb begin
      pulse_diff = $signed({req_ff.left_pulses[psf_pkg::PULSE_BITS-1], req_ff.left_pulses})
                 - $signed({req_ff.right_pulses[psf_pkg::PULSE_BITS-1], req_ff.right_pulses});
      dx  = $signed({position_ff[31], position_ff})
          - $signed({last_position_ff[31], last_position_ff});
      dth = $signed({th_ff[31], th_ff}) - $signed({last_angle_ff[31], last_angle_ff});

      case (ctl.mul_sel)
         psf_pkg::MUL_SAMPLE: begin
            mul_a = psf_pkg::ANGLE_PER_COUNT;
            mul_b = $signed({{(33 - psf_pkg::SAMPLE_BITS){1'b0}}, req_ff.angle_sample});
         end
         psf_pkg::MUL_PULSES: begin
            mul_a = psf_pkg::HALF_MPP_Q32;
            mul_b = $signed({{(32 - psf_pkg::PULSE_BITS){pulse_diff[psf_pkg::PULSE_BITS]}},
                             pulse_diff});
         end
         psf_pkg::MUL_ANGLE: begin
            mul_a = $signed({gain_angle_ff[31], gain_angle_ff});
            mul_b = $signed({th_ff[31], th_ff});
         end
         psf_pkg::MUL_POS: begin
            mul_a = $signed({gain_position_ff[31], gain_position_ff});
            mul_b = $signed({position_ff[31], position_ff});
         end
         psf_pkg::MUL_VEL: begin
            mul_a = $signed({gain_velocity_ff[31], gain_velocity_ff});
            mul_b = dx;
         end
         psf_pkg::MUL_RATE: begin
            mul_a = $signed({gain_angle_rate_ff[31], gain_angle_rate_ff});
            mul_b = dth;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = mul_a * mul_b;

      if (ctl.rnd_sel == psf_pkg::RND_ANG) begin
         rnd = (prod_ff + (64'sd1 <<< (psf_pkg::RND_ANG_SHIFT - 1))) >>> psf_pkg::RND_ANG_SHIFT;
      end else begin
         rnd = (prod_ff + (64'sd1 <<< (psf_pkg::RND_POS_SHIFT - 1))) >>> psf_pkg::RND_POS_SHIFT;
      end
      rnd_x100 = (rnd <<< 6) + (rnd <<< 5) + (rnd <<< 2);

      case (ctl.acc_op)
         psf_pkg::ACC_LOAD:     acc_in = rnd;
         psf_pkg::ACC_ADD:      acc_in = acc_ff + rnd;
         psf_pkg::ACC_ADD_X100: acc_in = acc_ff + rnd_x100;
         default:               acc_in = acc_ff;
      endcase

      th_wide = $signed({34'd0, angle_offset_ff}) - prod_ff;
      if (th_wide > psf_pkg::ANGLE_MAX) begin
         th_in = psf_pkg::ANGLE_MAX[31:0];
      end else if (th_wide < psf_pkg::ANGLE_MIN) begin
         th_in = psf_pkg::ANGLE_MIN[31:0];
      end else begin
         th_in = th_wide[31:0];
      end

      pos_base  = req_ff.zero_position ? 32'sd0 : position_ff;
      pos_round = (prod_ff + (64'sd1 <<< (psf_pkg::PULSE_SHIFT - 1))) >>> psf_pkg::PULSE_SHIFT;
      pos_sum   = $signed({{2{pos_base[31]}}, pos_base}) + $signed(pos_round[33:0]);
      if (pos_sum > psf_pkg::POS_LIMIT) begin
         position_in = psf_pkg::POS_LIMIT[31:0];
      end else if (pos_sum < -psf_pkg::POS_LIMIT) begin
         position_in = $signed(-psf_pkg::POS_LIMIT[31:0]);
      end else begin
         position_in = pos_sum[31:0];
      end

      drive_wide = (acc_ff + (64'sd1 <<< (psf_pkg::DRIVE_SHIFT - 1))) >>> psf_pkg::DRIVE_SHIFT;
      if (drive_wide > psf_pkg::DRIVE_MAX) begin
         rsp_in.drive         = psf_pkg::DRIVE_MAX[15:0];
         rsp_in.drive_clipped = 1'b1;
      end else if (drive_wide < -psf_pkg::DRIVE_MAX) begin
         rsp_in.drive         = $signed(-psf_pkg::DRIVE_MAX[15:0]);
         rsp_in.drive_clipped = 1'b1;
      end else begin
         rsp_in.drive         = drive_wide[15:0];
         rsp_in.drive_clipped = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= psf_pkg::STEP_IDLE;
         rsp_valid_ff     <= 1'b0;
         position_ff      <= '0;
         last_position_ff <= '0;
         last_angle_ff    <= '0;
      end else begin
         step_ff <= step_in;
         if (ctl.finish && go) begin
            rsp_valid_ff     <= 1'b1;
            last_position_ff <= position_ff;
            last_angle_ff    <= th_ff;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.pos_load) begin
            position_ff <= position_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      prod_ff <= product[63:0];
      acc_ff  <= acc_in;
      if (req_take) begin
         req_ff <= req_data;
      end
      if (ctl.th_load) begin
         th_ff <= th_in;
      end
      if (ctl.finish && go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= psf_pkg::STEP_LAST)
      else $error("sequencer step beyond program end");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> step_ff == psf_pkg::STEP_IDLE + 1'b1)
      else $error("transfer did not start the program");

   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      $signed({position_ff[31], position_ff, 1'b0}) <= (psf_pkg::POS_LIMIT <<< 1)
      && $signed({position_ff[31], position_ff, 1'b0}) >= -(psf_pkg::POS_LIMIT <<< 1))
      else $error("position outside saturation limit");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == psf_pkg::STEP_LAST)
      else $error("result raised outside final step");

endmodule
`default_nettype wire
